// ===== hdl/mouse_keyboard_input_port_defines.svh =====
// assertion macros for the mouse and keyboard input port
// used by the top level; expects i_clk and i_rst_n in scope
`ifndef MOUSE_KEYBOARD_INPUT_PORT_DEFINES_SVH
`define MOUSE_KEYBOARD_INPUT_PORT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MKIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MKIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mkip_pkg.sv =====
// shared types, codes and helpers for the mouse and keyboard input port
// no dependencies
package mkip_pkg;

    // commands
    localparam logic [3:0] CMD_MOVE       = 4'd0;
    localparam logic [3:0] CMD_BUTTON     = 4'd1;
    localparam logic [3:0] CMD_KEY        = 4'd2;
    localparam logic [3:0] CMD_SERVICE    = 4'd3;
    localparam logic [3:0] CMD_READ_BYTE  = 4'd4;
    localparam logic [3:0] CMD_READ_WORD  = 4'd5;
    localparam logic [3:0] CMD_WRITE_BYTE = 4'd6;
    localparam logic [3:0] CMD_WRITE_WORD = 4'd7;
    localparam logic [3:0] CMD_REINIT     = 4'd8;

    // software register map
    localparam logic [2:0] REG_X       = 3'd0;
    localparam logic [2:0] REG_Y       = 3'd1;
    localparam logic [2:0] REG_DELTA_X = 3'd2;
    localparam logic [2:0] REG_DELTA_Y = 3'd3;
    localparam logic [2:0] REG_SENS    = 3'd4;
    localparam logic [2:0] REG_BUTTONS = 3'd5;

    // configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

    // interrupt sources
    localparam logic [1:0] IRQ_NONE  = 2'd0;
    localparam logic [1:0] IRQ_KEY   = 2'd1;
    localparam logic [1:0] IRQ_MOUSE = 2'd2;

    // host button numbers and their register bits
    localparam logic [7:0] HOST_BTN_LEFT   = 8'd1;
    localparam logic [7:0] HOST_BTN_MIDDLE = 8'd2;
    localparam logic [7:0] HOST_BTN_RIGHT  = 8'd3;
    localparam logic [7:0] BTN_LEFT        = 8'h01;
    localparam logic [7:0] BTN_RIGHT       = 8'h02;
    localparam logic [7:0] BTN_MIDDLE      = 8'h04;

    localparam logic [15:0] FALLBACK_X   = 16'd319;
    localparam logic [15:0] FALLBACK_Y   = 16'd199;
    localparam logic [15:0] RESET_X      = 16'd159;
    localparam logic [15:0] RESET_Y      = 16'd99;
    localparam logic [31:0] SENS_DEFAULT = 32'd256;

    typedef struct packed {
        logic [3:0]         cmd;
        logic signed [15:0] move_dx;
        logic signed [15:0] move_dy;
        logic [7:0]         button_code;
        logic               pressed;
        logic [2:0]         reg_index;
        logic [31:0]        write_data;
    } t_in_req;

    typedef struct packed {
        logic [31:0] read_data;
        logic [1:0]  irq_source;
    } t_out_rsp;

    // outcome of a move event
    typedef struct packed {
        logic [15:0] ptr_x;
        logic [15:0] ptr_y;
        logic [31:0] step_x;
        logic [31:0] step_y;
    } t_move_res;

    // largest legal coordinate for a screen dimension
    function automatic logic [15:0] bound_of(input logic [15:0] size,
                                             input logic [15:0] fallback);
        bound_of = (size == 16'd0) ? fallback : size - 16'd1;
    endfunction

    // clamp a signed value into 0..bound
    function automatic logic [15:0] clamp_pos(input logic signed [33:0] v,
                                              input logic [15:0] bound);
        if (v < 0)
            clamp_pos = 16'd0;
        else if (v > $signed({18'd0, bound}))
            clamp_pos = bound;
        else
            clamp_pos = v[15:0];
    endfunction

endpackage

// ===== hdl/mouse_keyboard_input_port.sv =====
// top level of the mouse and keyboard input port: state, register access, result stage
// depends on mkip_pkg, mkip_motion and mouse_keyboard_input_port_defines.svh
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_stall        i_in_req   (t_in_req)
//  result    out        o_out_valid / i_out_stall      o_out_rsp  (t_out_rsp)
//  config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// every request yields one result, registered in the cycle after it is taken; a request can be
// taken every cycle unless a held result is stalled, the pace set by the single result register
// the move path (16x33 multiply, pointer add, clamp) is the longest path
// reset is synchronous, active low; it restores the centred pointer and default sensitivity and clears the rest
// a stalled result holds in the result register and stalls the input only while full
// config writes are always taken (ready held high)
`include "mouse_keyboard_input_port_defines.svh"

module mouse_keyboard_input_port #(
    parameter int unsigned KEY_BUFFER_DEPTH = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  mkip_pkg::t_in_req                  i_in_req,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output mkip_pkg::t_out_rsp                 o_out_rsp,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mkip_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import mkip_pkg::*;

    localparam int unsigned KEY_W = (KEY_BUFFER_DEPTH > 1) ? $clog2(KEY_BUFFER_DEPTH) : 1;
    localparam logic [KEY_W-1:0] KEY_MAX = KEY_W'(KEY_BUFFER_DEPTH - 1);

    // screen configuration
    logic [15:0] r_screen_w;
    logic [15:0] r_screen_h;

    // mouse state; pointer is always kept within 0..65534 so 16 bits hold it
    logic [15:0]      r_ptr_x,     n_ptr_x;
    logic [15:0]      r_ptr_y,     n_ptr_y;
    logic [31:0]      r_delta_x,   n_delta_x;
    logic [31:0]      r_delta_y,   n_delta_y;
    logic [31:0]      r_sens,      n_sens;
    logic [7:0]       r_buttons,   n_buttons;
    logic [KEY_W-1:0] r_key_count, n_key_count;
    logic             r_key_irq,   n_key_irq;
    logic             r_mouse_irq, n_mouse_irq;

    // result stage
    logic     r_out_valid;
    t_out_rsp r_out_rsp, n_out_rsp;

    logic        w_in_acc;
    logic        w_out_acc;
    logic [15:0] w_bound_x;
    logic [15:0] w_bound_y;
    logic [31:0] w_rd_val;
    logic [7:0]  w_btn_bit;
    logic [7:0]  w_wr_byte;
    t_move_res   w_move;

    // handshakes: input only stalls while a result is held and the sink stalls
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;
    assign o_cfg_ready = 1'b1;

    assign w_bound_x = bound_of(r_screen_w, FALLBACK_X);
    assign w_bound_y = bound_of(r_screen_h, FALLBACK_Y);
    assign w_wr_byte = i_in_req.write_data[7:0];

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= 16'd0;
            r_screen_h <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    mkip_motion u_motion (
        .i_dx      (i_in_req.move_dx),
        .i_dy      (i_in_req.move_dy),
        .i_sens    (r_sens),
        .i_ptr_x   (r_ptr_x),
        .i_ptr_y   (r_ptr_y),
        .i_bound_x (w_bound_x),
        .i_bound_y (w_bound_y),
        .o_res     (w_move)
    );

    // register read mux; pointer reads are clamped to the current bounds
    always_comb begin
        case (i_in_req.reg_index)
            REG_X:       w_rd_val = {16'd0, clamp_pos($signed({18'd0, r_ptr_x}), w_bound_x)};
            REG_Y:       w_rd_val = {16'd0, clamp_pos($signed({18'd0, r_ptr_y}), w_bound_y)};
            REG_DELTA_X: w_rd_val = r_delta_x;
            REG_DELTA_Y: w_rd_val = r_delta_y;
            REG_SENS:    w_rd_val = r_sens;
            REG_BUTTONS: w_rd_val = {24'd0, r_buttons};
            default:     w_rd_val = 32'd0;
        endcase
    end

    // host button number to register bit; unknown codes map to none
    always_comb begin
        case (i_in_req.button_code)
            HOST_BTN_LEFT:   w_btn_bit = BTN_LEFT;
            HOST_BTN_RIGHT:  w_btn_bit = BTN_RIGHT;
            HOST_BTN_MIDDLE: w_btn_bit = BTN_MIDDLE;
            default:         w_btn_bit = 8'd0;
        endcase
    end

    // next state and result for the request on the port
    always_comb begin
        n_ptr_x     = r_ptr_x;
        n_ptr_y     = r_ptr_y;
        n_delta_x   = r_delta_x;
        n_delta_y   = r_delta_y;
        n_sens      = r_sens;
        n_buttons   = r_buttons;
        n_key_count = r_key_count;
        n_key_irq   = r_key_irq;
        n_mouse_irq = r_mouse_irq;
        n_out_rsp   = '0;

        case (i_in_req.cmd)
            CMD_MOVE: begin
                n_ptr_x     = w_move.ptr_x;
                n_ptr_y     = w_move.ptr_y;
                n_delta_x   = r_delta_x + w_move.step_x;
                n_delta_y   = r_delta_y + w_move.step_y;
                n_mouse_irq = 1'b1;
            end
            CMD_BUTTON: begin
                if (w_btn_bit != 8'd0) begin
                    n_buttons   = i_in_req.pressed ? (r_buttons | w_btn_bit)
                                                   : (r_buttons & ~w_btn_bit);
                    n_mouse_irq = 1'b1;
                end
            end
            CMD_KEY: begin
                // a full buffer drops the key silently
                if (r_key_count < KEY_MAX) begin
                    n_key_count = r_key_count + KEY_W'(1);
                    n_key_irq   = 1'b1;
                end
            end
            CMD_SERVICE: begin
                // keyboard has priority over mouse
                if (r_key_irq) begin
                    n_key_irq            = 1'b0;
                    n_out_rsp.irq_source = IRQ_KEY;
                end else if (r_mouse_irq) begin
                    n_mouse_irq          = 1'b0;
                    n_out_rsp.irq_source = IRQ_MOUSE;
                end else begin
                    n_out_rsp.irq_source = IRQ_NONE;
                end
            end
            CMD_READ_BYTE: begin
                n_out_rsp.read_data = {24'd0, w_rd_val[7:0]};
            end
            CMD_READ_WORD: begin
                n_out_rsp.read_data = w_rd_val;
            end
            CMD_WRITE_BYTE: begin
                // byte writes patch the low byte; buttons take the byte whole
                case (i_in_req.reg_index)
                    REG_X:       n_ptr_x = clamp_pos($signed({18'd0, r_ptr_x[15:8], w_wr_byte}),
                                                     w_bound_x);
                    REG_Y:       n_ptr_y = clamp_pos($signed({18'd0, r_ptr_y[15:8], w_wr_byte}),
                                                     w_bound_y);
                    REG_DELTA_X: n_delta_x = {r_delta_x[31:8], w_wr_byte};
                    REG_DELTA_Y: n_delta_y = {r_delta_y[31:8], w_wr_byte};
                    REG_SENS:    n_sens    = {r_sens[31:8], w_wr_byte};
                    REG_BUTTONS: n_buttons = w_wr_byte;
                    default: ;
                endcase
            end
            CMD_WRITE_WORD: begin
                // pointer words are signed and clamped
                case (i_in_req.reg_index)
                    REG_X:       n_ptr_x = clamp_pos($signed({{2{i_in_req.write_data[31]}},
                                                              i_in_req.write_data}), w_bound_x);
                    REG_Y:       n_ptr_y = clamp_pos($signed({{2{i_in_req.write_data[31]}},
                                                              i_in_req.write_data}), w_bound_y);
                    REG_DELTA_X: n_delta_x = i_in_req.write_data;
                    REG_DELTA_Y: n_delta_y = i_in_req.write_data;
                    REG_SENS:    n_sens    = i_in_req.write_data;
                    REG_BUTTONS: n_buttons = w_wr_byte;
                    default: ;
                endcase
            end
            CMD_REINIT: begin
                // pointer recentres on the current bounds
                n_ptr_x     = {1'b0, w_bound_x[15:1]};
                n_ptr_y     = {1'b0, w_bound_y[15:1]};
                n_delta_x   = 32'd0;
                n_delta_y   = 32'd0;
                n_sens      = SENS_DEFAULT;
                n_buttons   = 8'd0;
                n_key_count = '0;
                n_key_irq   = 1'b0;
                n_mouse_irq = 1'b0;
            end
            default: ;
        endcase
    end

    // state update on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr_x     <= RESET_X;
            r_ptr_y     <= RESET_Y;
            r_delta_x   <= 32'd0;
            r_delta_y   <= 32'd0;
            r_sens      <= SENS_DEFAULT;
            r_buttons   <= 8'd0;
            r_key_count <= '0;
            r_key_irq   <= 1'b0;
            r_mouse_irq <= 1'b0;
        end else if (w_in_acc) begin
            r_ptr_x     <= n_ptr_x;
            r_ptr_y     <= n_ptr_y;
            r_delta_x   <= n_delta_x;
            r_delta_y   <= n_delta_y;
            r_sens      <= n_sens;
            r_buttons   <= n_buttons;
            r_key_count <= n_key_count;
            r_key_irq   <= n_key_irq;
            r_mouse_irq <= n_mouse_irq;
        end
    end

    // result register: loads on accept, empties when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_rsp <= n_out_rsp;
        end
    end

    // every accepted request leaves a result in the output register
    `MKIP_ASSERT_NEXT(a_result_follows, w_in_acc, r_out_valid, "request without result")
    // key counter never passes the buffer limit
    `MKIP_ASSERT_NOW(a_key_bound, 1'b1, r_key_count <= KEY_MAX, "key count overflow")
    // servicing a pending keyboard interrupt clears it
    `MKIP_ASSERT_NEXT(a_key_ack, w_in_acc && i_in_req.cmd == CMD_SERVICE && r_key_irq, !r_key_irq, "key irq not cleared")
    // reinit clears buttons and key buffer
    `MKIP_ASSERT_NEXT(a_reinit, w_in_acc && i_in_req.cmd == CMD_REINIT, r_buttons == 8'd0 && r_key_count == '0, "reinit left state")

endmodule

// ===== hdl/mkip_motion.sv =====
// motion datapath: sensitivity scaling, pointer update with clamping
// depends on mkip_pkg
module mkip_motion (
    input  logic signed [15:0] i_dx,
    input  logic signed [15:0] i_dy,
    input  logic [31:0]        i_sens,
    input  logic [15:0]        i_ptr_x,
    input  logic [15:0]        i_ptr_y,
    input  logic [15:0]        i_bound_x,
    input  logic [15:0]        i_bound_y,
    output mkip_pkg::t_move_res o_res
);
    import mkip_pkg::*;

    logic [31:0]        w_sens;
    logic signed [32:0] w_sens_s;
    logic signed [48:0] w_prod_x;
    logic signed [48:0] w_prod_y;
    logic [31:0]        w_step_x;
    logic [31:0]        w_step_y;
    logic signed [33:0] w_sum_x;
    logic signed [33:0] w_sum_y;

    // zero sensitivity means unity gain
    assign w_sens   = (i_sens == 32'd0) ? SENS_DEFAULT : i_sens;
    assign w_sens_s = $signed({1'b0, w_sens});

    assign w_prod_x = i_dx * w_sens_s;
    assign w_prod_y = i_dy * w_sens_s;

    // arithmetic shift gives floor of the division by 256
    assign w_step_x = w_prod_x[39:8];
    assign w_step_y = w_prod_y[39:8];

    assign w_sum_x = $signed({18'd0, i_ptr_x}) + $signed({{2{w_step_x[31]}}, w_step_x});
    assign w_sum_y = $signed({18'd0, i_ptr_y}) + $signed({{2{w_step_y[31]}}, w_step_y});

    assign o_res.ptr_x  = clamp_pos(w_sum_x, i_bound_x);
    assign o_res.ptr_y  = clamp_pos(w_sum_y, i_bound_y);
    assign o_res.step_x = w_step_x;
    assign o_res.step_y = w_step_y;

endmodule

// ===== tb/sv/mouse_keyboard_input_port_tb.sv =====
// self-checking testbench for the mouse and keyboard input port
// depends on mkip_pkg and the mouse_keyboard_input_port top level
`timescale 1ns / 1ps

module mouse_keyboard_input_port_tb;
    import mkip_pkg::*;

    localparam int unsigned KEY_DEPTH = 256;
    // command codes the block does not decode, and register slots with nothing behind them
    localparam logic [3:0] CMD_SPARE    = 4'd15;
    localparam logic [2:0] REG_SPARE_LO = 3'd6;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // one row of the directed table; chk marks a result typed in by hand
    typedef struct {
        t_in_req  req;
        bit       chk;
        t_out_rsp rsp;
    } t_dir_row;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 in_stall;
    t_in_req              req_bus   = '0;
    logic                 rsp_valid;
    logic                 out_stall = 1'b0;
    t_out_rsp             rsp_bus;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [15:0]          cfg_data  = '0;

    // shadow of the port state, advanced once per accepted request
    bit [15:0] scr_w;
    bit [15:0] scr_h;
    int        ptr_x;
    int        ptr_y;
    bit [31:0] acc_dx;
    bit [31:0] acc_dy;
    bit [31:0] sens_q;
    bit [7:0]  btn_bits;
    int        keys_held;
    bit        key_irq;
    bit        mouse_irq;

    t_out_rsp  awaited_rsp[$];
    t_out_rsp  want_rsp;
    t_dir_row  dir_rows[26];
    bit        gaps_on;
    bit        stalls_on;
    int        stall_cnt       = 0;
    int        requests_sent   = 0;
    int        results_checked = 0;
    int        screen_settings = 0;
    int        errors          = 0;

    mouse_keyboard_input_port #(
        .KEY_BUFFER_DEPTH(KEY_DEPTH)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (req_bus),
        .o_out_valid (rsp_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (rsp_bus),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    // largest legal coordinate; a zero size falls back to the low-res screen
    function automatic longint axis_bound(input bit [15:0] size, input bit [15:0] fallback);
        return (size == 16'd0) ? longint'(fallback) : longint'(size) - 1;
    endfunction

    function automatic int clip(input longint v, input longint top);
        if (v < 0)
            return 0;
        if (v > top)
            return int'(top);
        return int'(v);
    endfunction

    // floor(d * s / 256) kept to 32 bits; the arithmetic shift gives the floor for negatives
    function automatic bit [31:0] scaled_step(input logic signed [15:0] d, input bit [31:0] s);
        longint prod;
        prod = longint'(d) * longint'({32'd0, s});
        return prod[39:8];
    endfunction

    // pointer centred on the current bounds, everything else back to idle
    function automatic void centre_state();
        ptr_x     = int'(axis_bound(scr_w, FALLBACK_X) / 2);
        ptr_y     = int'(axis_bound(scr_h, FALLBACK_Y) / 2);
        acc_dx    = '0;
        acc_dy    = '0;
        sens_q    = SENS_DEFAULT;
        btn_bits  = '0;
        keys_held = 0;
        key_irq   = 1'b0;
        mouse_irq = 1'b0;
    endfunction

    // pointer reads are clamped again to the bounds in force now
    function automatic bit [31:0] reg_value(input bit [2:0] idx);
        case (idx)
            REG_X:       return clip(ptr_x, axis_bound(scr_w, FALLBACK_X));
            REG_Y:       return clip(ptr_y, axis_bound(scr_h, FALLBACK_Y));
            REG_DELTA_X: return acc_dx;
            REG_DELTA_Y: return acc_dy;
            REG_SENS:    return sens_q;
            REG_BUTTONS: return {24'd0, btn_bits};
            default:     return '0;
        endcase
    endfunction

    function automatic void reg_store(input bit [2:0] idx, input bit [31:0] val,
                                      input bit byte_only);
        bit [31:0] low_x;
        bit [31:0] low_y;
        low_x = (ptr_x & ~32'hFF) | {24'd0, val[7:0]};
        low_y = (ptr_y & ~32'hFF) | {24'd0, val[7:0]};
        case (idx)
            REG_X: ptr_x = clip(byte_only ? longint'(low_x) : longint'($signed(val)),
                                axis_bound(scr_w, FALLBACK_X));
            REG_Y: ptr_y = clip(byte_only ? longint'(low_y) : longint'($signed(val)),
                                axis_bound(scr_h, FALLBACK_Y));
            REG_DELTA_X: acc_dx = byte_only ? {acc_dx[31:8], val[7:0]} : val;
            REG_DELTA_Y: acc_dy = byte_only ? {acc_dy[31:8], val[7:0]} : val;
            REG_SENS:    sens_q = byte_only ? {sens_q[31:8], val[7:0]} : val;
            REG_BUTTONS: btn_bits = val[7:0];
            default: ;
        endcase
    endfunction

    // result of one request, advancing the shadow state
    function automatic t_out_rsp next_port_rsp(input t_in_req req);
        t_out_rsp  rsp;
        bit [31:0] step;
        bit [31:0] sx;
        bit [31:0] sy;
        bit [31:0] rd;
        bit [7:0]  sel;
        rsp = '0;
        case (req.cmd)
            CMD_MOVE: begin
                // zero sensitivity behaves as unity
                step  = (sens_q == 0) ? SENS_DEFAULT : sens_q;
                sx    = scaled_step(req.move_dx, step);
                sy    = scaled_step(req.move_dy, step);
                ptr_x = clip(longint'(ptr_x) + longint'($signed(sx)),
                             axis_bound(scr_w, FALLBACK_X));
                ptr_y = clip(longint'(ptr_y) + longint'($signed(sy)),
                             axis_bound(scr_h, FALLBACK_Y));
                acc_dx    = acc_dx + sx;
                acc_dy    = acc_dy + sy;
                mouse_irq = 1'b1;
            end
            CMD_BUTTON: begin
                case (req.button_code)
                    HOST_BTN_LEFT:   sel = BTN_LEFT;
                    HOST_BTN_RIGHT:  sel = BTN_RIGHT;
                    HOST_BTN_MIDDLE: sel = BTN_MIDDLE;
                    default:         sel = '0;
                endcase
                // unknown buttons leave state and interrupts alone
                if (sel != 0) begin
                    btn_bits  = req.pressed ? (btn_bits | sel) : (btn_bits & ~sel);
                    mouse_irq = 1'b1;
                end
            end
            CMD_KEY: begin
                // buffer full: key dropped, no interrupt
                if (keys_held < KEY_DEPTH - 1) begin
                    keys_held++;
                    key_irq = 1'b1;
                end
            end
            CMD_SERVICE: begin
                if (key_irq) begin
                    key_irq        = 1'b0;
                    rsp.irq_source = IRQ_KEY;
                end else if (mouse_irq) begin
                    mouse_irq      = 1'b0;
                    rsp.irq_source = IRQ_MOUSE;
                end
            end
            CMD_READ_BYTE: begin
                rd            = reg_value(req.reg_index);
                rsp.read_data = {24'd0, rd[7:0]};
            end
            CMD_READ_WORD:  rsp.read_data = reg_value(req.reg_index);
            CMD_WRITE_BYTE: reg_store(req.reg_index, req.write_data, 1'b1);
            CMD_WRITE_WORD: reg_store(req.reg_index, req.write_data, 1'b0);
            CMD_REINIT:     centre_state();
            default: ;
        endcase
        return rsp;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic t_dir_row row(input logic [3:0] cmd, input logic [2:0] idx,
                                     input logic [31:0] wdata, input logic [15:0] dx,
                                     input logic [15:0] dy, input logic [7:0] code,
                                     input logic pr, input bit chk, input logic [31:0] rd,
                                     input logic [1:0] irq);
        t_dir_row r;
        r.req.cmd         = cmd;
        r.req.move_dx     = dx;
        r.req.move_dy     = dy;
        r.req.button_code = code;
        r.req.pressed     = pr;
        r.req.reg_index   = idx;
        r.req.write_data  = wdata;
        r.chk             = chk;
        r.rsp.read_data   = rd;
        r.rsp.irq_source  = irq;
        return r;
    endfunction

    // small motion most of the time, with full-range and extreme values mixed in
    function automatic logic signed [15:0] motion();
        case ($urandom_range(0, 3))
            0, 1:    return 16'($urandom_range(0, 128) - 64);
            2:       return 16'($urandom);
            default: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        endcase
    endfunction

    // every field starts fully random, then the one the command uses is shaped
    function automatic t_in_req random_request(input bit flood);
        t_in_req r;
        int      pick;
        r.move_dx     = 16'($urandom);
        r.move_dy     = 16'($urandom);
        r.button_code = 8'($urandom);
        r.pressed     = 1'($urandom);
        r.reg_index   = 3'($urandom);
        r.write_data  = $urandom;
        pick          = $urandom_range(0, 99);
        if (flood)
            r.cmd = (pick < 85) ? CMD_KEY : CMD_SERVICE;
        else if (pick < 24)
            r.cmd = CMD_MOVE;
        else if (pick < 36)
            r.cmd = CMD_BUTTON;
        else if (pick < 46)
            r.cmd = CMD_KEY;
        else if (pick < 58)
            r.cmd = CMD_SERVICE;
        else if (pick < 66)
            r.cmd = CMD_READ_BYTE;
        else if (pick < 78)
            r.cmd = CMD_READ_WORD;
        else if (pick < 85)
            r.cmd = CMD_WRITE_BYTE;
        else if (pick < 93)
            r.cmd = CMD_WRITE_WORD;
        else if (pick < 95)
            r.cmd = CMD_REINIT;
        else
            r.cmd = 4'($urandom_range(CMD_REINIT + 1, CMD_SPARE));
        case (r.cmd)
            CMD_MOVE: begin
                r.move_dx = motion();
                r.move_dy = motion();
            end
            CMD_BUTTON: begin
                if ($urandom_range(0, 4) != 0)
                    r.button_code = 8'($urandom_range(HOST_BTN_LEFT, HOST_BTN_RIGHT));
            end
            CMD_WRITE_BYTE, CMD_WRITE_WORD: begin
                if ($urandom_range(0, 7) != 0)
                    r.reg_index = 3'($urandom_range(REG_X, REG_BUTTONS));
                // sensitivity: zero, all ones, anything, or a usable gain
                if (r.reg_index == REG_SENS) begin
                    case ($urandom_range(0, 4))
                        0:       r.write_data = '0;
                        1:       r.write_data = '1;
                        2:       r.write_data = $urandom;
                        default: r.write_data = $urandom_range(0, 1024);
                    endcase
                end else if ($urandom_range(0, 1)) begin
                    r.write_data = $urandom_range(0, 700);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // hold the request until taken; the expectation is queued at the accepting edge
    task automatic send_request(input t_in_req req, input bit chk, input t_out_rsp typed);
        int       gap;
        t_out_rsp rsp;
        gap = gaps_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_bus   <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        rsp = next_port_rsp(req);
        awaited_rsp.push_back(chk ? typed : rsp);
        requests_sent++;
    endtask

    // sender stays quiet until every outstanding result is back
    task automatic drain_results();
        while (awaited_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // both screen registers, back to back on the config channel
    task automatic program_screen(input bit [15:0] w, input bit [15:0] h);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_SCREEN_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scr_w = w;
        cfg_index <= CFG_SCREEN_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        scr_h = h;
        cfg_valid <= 1'b0;
        screen_settings++;
    endtask

    task automatic run_phase(input bit [15:0] w, input bit [15:0] h, input int count,
                             input bit flood, input bit gaps, input bit stalls);
        t_in_req wipe;
        gaps_on   = gaps;
        stalls_on = stalls;
        program_screen(w, h);
        // key flood starts from an empty buffer so that it fills up
        if (flood) begin
            wipe     = '0;
            wipe.cmd = CMD_REINIT;
            send_request(wipe, 1'b0, '0);
        end
        repeat (count)
            send_request(random_request(flood), 1'b0, '0);
        req_valid <= 1'b0;
        drain_results();
    endtask

    // ---------------------------------------------------------------- result check

    // a result is taken at an edge where valid is high and our stall was low;
    // the stall for the next one is drawn as each result goes by
    always @(posedge clk) begin
        if (rst_n && rsp_valid && !out_stall) begin
            results_checked++;
            if (awaited_rsp.size() == 0) begin
                $display("%0t: unexpected result read_data=%h irq_source=%0d",
                         $time, rsp_bus.read_data, rsp_bus.irq_source);
                errors++;
            end else begin
                want_rsp = awaited_rsp.pop_front();
                if (rsp_bus.read_data !== want_rsp.read_data) begin
                    $display("%0t: read_data expected %h actual %h",
                             $time, want_rsp.read_data, rsp_bus.read_data);
                    errors++;
                end
                if (rsp_bus.irq_source !== want_rsp.irq_source) begin
                    $display("%0t: irq_source expected %0d actual %0d",
                             $time, want_rsp.irq_source, rsp_bus.irq_source);
                    errors++;
                end
            end
            stall_cnt = stalls_on ? $urandom_range(0, 11) : 0;
        end
        out_stall <= (stall_cnt != 0);
        if (stall_cnt != 0)
            stall_cnt--;
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        // directed rows: reset values, clamps at both edges, interrupt order,
        // ignored button, zero sensitivity, byte patch of the pointer, unmapped slots
        //                  cmd             idx           wdata          dx         dy
        //                  code             pr chk rd        irq
        dir_rows[0]  = row(CMD_READ_WORD,  REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd159, IRQ_NONE);
        dir_rows[1]  = row(CMD_READ_WORD,  REG_SENS,     '0,            '0,        '0,
                           '0,              0, 1, 32'd256, IRQ_NONE);
        dir_rows[2]  = row(CMD_SERVICE,    REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_NONE);
        dir_rows[3]  = row(CMD_SPARE,      REG_SPARE_HI, 32'hFFFF_FFFF, 16'hFFFF,  16'hFFFF,
                           8'hFF,           1, 1, 32'd0,   IRQ_NONE);
        dir_rows[4]  = row(CMD_MOVE,       REG_X,        '0,            16'h7FFF,  16'h8000,
                           '0,              0, 1, 32'd0,   IRQ_NONE);
        dir_rows[5]  = row(CMD_READ_WORD,  REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd319, IRQ_NONE);
        dir_rows[6]  = row(CMD_READ_WORD,  REG_Y,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_NONE);
        dir_rows[7]  = row(CMD_SERVICE,    REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_MOUSE);
        dir_rows[8]  = row(CMD_KEY,        REG_X,        '0,            '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[9]  = row(CMD_BUTTON,     REG_X,        '0,            '0,        '0,
                           HOST_BTN_LEFT,   1, 0, '0,      IRQ_NONE);
        dir_rows[10] = row(CMD_SERVICE,    REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_KEY);
        dir_rows[11] = row(CMD_SERVICE,    REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_MOUSE);
        dir_rows[12] = row(CMD_BUTTON,     REG_X,        '0,            '0,        '0,
                           8'hFF,           1, 0, '0,      IRQ_NONE);
        dir_rows[13] = row(CMD_SERVICE,    REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_NONE);
        dir_rows[14] = row(CMD_BUTTON,     REG_X,        '0,            '0,        '0,
                           HOST_BTN_RIGHT,  1, 0, '0,      IRQ_NONE);
        dir_rows[15] = row(CMD_BUTTON,     REG_X,        '0,            '0,        '0,
                           HOST_BTN_MIDDLE, 1, 0, '0,      IRQ_NONE);
        dir_rows[16] = row(CMD_READ_BYTE,  REG_BUTTONS,  '0,            '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[17] = row(CMD_WRITE_WORD, REG_SENS,     32'd0,         '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[18] = row(CMD_MOVE,       REG_X,        '0,            16'hFFFF,  16'h0001,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[19] = row(CMD_WRITE_BYTE, REG_X,        32'hFFFF_FFAB, '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[20] = row(CMD_WRITE_WORD, REG_Y,        32'hFFFF_FFFF, '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[21] = row(CMD_READ_WORD,  REG_DELTA_X,  '0,            '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[22] = row(CMD_READ_BYTE,  REG_SPARE_LO, '0,            '0,        '0,
                           '0,              0, 1, 32'd0,   IRQ_NONE);
        dir_rows[23] = row(CMD_WRITE_WORD, REG_SPARE_HI, 32'hFFFF_FFFF, '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[24] = row(CMD_REINIT,     REG_X,        '0,            '0,        '0,
                           '0,              0, 0, '0,      IRQ_NONE);
        dir_rows[25] = row(CMD_READ_WORD,  REG_X,        '0,            '0,        '0,
                           '0,              0, 1, 32'd159, IRQ_NONE);

        // shadow starts from the reset configuration
        scr_w = '0;
        scr_h = '0;
        centre_state();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gaps_on   = 1'b1;
        stalls_on = 1'b1;
        foreach (dir_rows[i])
            send_request(dir_rows[i].req, dir_rows[i].chk, dir_rows[i].rsp);
        req_valid <= 1'b0;
        drain_results();

        // random phases: largest screen, single-pixel screen with no idling,
        // key flood, random size, fallback bounds, mixed sizes
        run_phase(16'hFFFF, 16'hFFFF, 250, 1'b0, 1'b1, 1'b1);
        run_phase(16'd1,    16'd1,    200, 1'b0, 1'b0, 1'b0);
        run_phase(16'd640,  16'd480,  330, 1'b1, 1'b1, 1'b1);
        run_phase(16'($urandom), 16'($urandom), 250, 1'b0, 1'b1, 1'b0);
        run_phase(16'd0,    16'd0,    250, 1'b0, 1'b0, 1'b1);
        run_phase(16'd320,  16'hFFFF, 150, 1'b0, 1'b1, 1'b1);

        $display("%0d requests sent under %0d screen settings, %0d results checked",
                 requests_sent, screen_settings, results_checked);
        $display("moves, buttons, key buffer overflow, irq order, register access and reinit");
        if (errors == 0)
            $display("mouse_keyboard_input_port: match");
        else
            $display("mouse_keyboard_input_port: mismatch");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("mouse_keyboard_input_port: mismatch");
        $finish;
    end

endmodule

// ===== mouse_keyboard_input_port.f =====
+incdir+hdl
hdl/mkip_pkg.sv
hdl/mkip_motion.sv
hdl/mouse_keyboard_input_port.sv
tb/sv/mouse_keyboard_input_port_tb.sv
